### rtl/core/mhpq_pkg.sv
package mhpq_pkg;

   // Heap geometry.
   localparam int HEAP_DEPTH  = 128;
   localparam int ADDR_W      = $clog2(HEAP_DEPTH);
   localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
   localparam int CHILD_W     = ADDR_W + 2;

   // Field widths of the channels.
   localparam int ID_W        = 10;
   localparam int PRIO_W      = 8;
   localparam int COUNT_OUT_W = 8;

   // Fill level at which an insert is turned away, and how it shows on the result.
   localparam logic [CNT_W-1:0]       FULL_COUNT     = CNT_W'(HEAP_DEPTH);
   localparam logic [COUNT_OUT_W-1:0] OUT_FULL_COUNT = COUNT_OUT_W'(HEAP_DEPTH);

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [CHILD_W-1:0] child_type;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [ID_W-1:0]   proc_id;
      logic [PRIO_W-1:0] prio;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]        out_id;
      logic [PRIO_W-1:0]      out_prio;
      logic                   got_entry;
      logic                   was_empty;
      logic                   was_full;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_type;

   // One heap slot as it sits in memory.
   typedef struct packed {
      logic [ID_W-1:0]   proc_id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_CMP,
      ST_DN_ROOT,
      ST_DN_LAST,
      ST_DN_LEFT,
      ST_DN_CMP,
      ST_PLACE,
      ST_FINISH
   } state_type;

   // Parent slot of a nonzero slot.
   function automatic addr_type parent_of(addr_type idx);
      addr_type dec;
      dec = idx - addr_type'(1);
      return dec >> 1;
   endfunction

   // Left and right child slots, wide enough to exceed the depth.
   function automatic child_type left_of(addr_type idx);
      child_type wide;
      wide = child_type'(idx);
      return (wide << 1) | child_type'(1);
   endfunction

   function automatic child_type right_of(addr_type idx);
      child_type wide;
      wide = child_type'(idx);
      return (wide << 1) + child_type'(2);
   endfunction

endpackage

### rtl/core/mhpq_ram.sv
module mhpq_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/max_heap_priority_queue.sv
// Binary max-heap priority queue with the heap held in one single-port-read memory.
// Insert: the new entry moves up one level per cycle.
// Remove: per level, a memory read of the left child and, when it exists, of the right child.
// One item is worked on at a time; the next is taken once the result is in the output register.
// Synchronous active-high reset empties the heap and the output register; memory is not cleared.
module max_heap_priority_queue
   import mhpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   addr_type          hole_ff, hole_in;
   entry_type         mov_ff, mov_in;
   entry_type         lft_ff, lft_in;
   rsp_type           pend_ff, pend_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              wr_en;
   addr_type          wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   addr_type          rd_addr;
   entry_type         rd_ent;

   child_type         cnt_ext;
   child_type         lchild;
   child_type         rchild;
   child_type         next_left;
   addr_type          up_parent;
   addr_type          best_idx;
   entry_type         best_ent;
   logic [PRIO_W-1:0] best_prio;
   logic              left_big;
   logic              right_big;
   logic              right_ok;

   mhpq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(HEAP_DEPTH)
   ) u_heap_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_ent)
   );

   // Index arithmetic around the current hole.
   assign cnt_ext   = child_type'(count_ff);
   assign lchild    = left_of(hole_ff);
   assign rchild    = right_of(hole_ff);
   assign right_ok  = rchild < cnt_ext;
   assign up_parent = parent_of(hole_ff);

   // Sift-down choice: left child if strictly larger than the moving entry,
   // then right child if strictly larger than that pick.
   always_comb begin
      left_big  = lft_ff.prio > mov_ff.prio;
      best_prio = left_big ? lft_ff.prio : mov_ff.prio;
      right_big = right_ok && (rd_ent.prio > best_prio);
      if (right_big) begin
         best_ent = rd_ent;
         best_idx = rchild[ADDR_W-1:0];
      end else begin
         best_ent = lft_ff;
         best_idx = lchild[ADDR_W-1:0];
      end
      next_left = left_of(best_idx);
   end

   // Next state and memory control.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hole_in      = hole_ff;
      mov_in       = mov_ff;
      lft_in       = lft_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = hole_ff;
      wr_data      = mov_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pend_in        = '0;
               mov_in.proc_id = req_payload.proc_id;
               mov_in.prio    = req_payload.prio;
               if (req_payload.cmd == CMD_INSERT) begin
                  if (count_ff == FULL_COUNT) begin
                     pend_in.was_full = 1'b1;
                     state_in         = ST_FINISH;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     hole_in  = count_ff[ADDR_W-1:0];
                     if (count_ff == '0) begin
                        // First entry lands at the root directly.
                        wr_en          = 1'b1;
                        wr_addr        = '0;
                        wr_data.proc_id = req_payload.proc_id;
                        wr_data.prio    = req_payload.prio;
                        state_in       = ST_FINISH;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = parent_of(count_ff[ADDR_W-1:0]);
                        state_in = ST_UP_CMP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     pend_in.was_empty = 1'b1;
                     state_in          = ST_FINISH;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_DN_ROOT;
                  end
               end
            end
         end

         // Parent of the hole is on the read port.
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (mov_ff.prio > rd_ent.prio) begin
               wr_data = rd_ent;
               hole_in = up_parent;
               if (up_parent == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = parent_of(up_parent);
               end
            end else begin
               state_in = ST_FINISH;
            end
         end

         // Root is on the read port; fetch the last entry if any remain.
         ST_DN_ROOT: begin
            pend_in.out_id    = rd_ent.proc_id;
            pend_in.out_prio  = rd_ent.prio;
            pend_in.got_entry = 1'b1;
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = count_ff[ADDR_W-1:0];
               state_in = ST_DN_LAST;
            end
         end

         // Last entry becomes the moving entry with the hole at the root.
         ST_DN_LAST: begin
            mov_in  = rd_ent;
            hole_in = '0;
            if (left_of('0) < cnt_ext) begin
               rd_en    = 1'b1;
               rd_addr  = '0 | addr_type'(1);
               state_in = ST_DN_LEFT;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = rd_ent;
               state_in = ST_FINISH;
            end
         end

         // Left child arrives; fetch the right one when it exists.
         ST_DN_LEFT: begin
            lft_in = rd_ent;
            if (right_ok) begin
               rd_en   = 1'b1;
               rd_addr = rchild[ADDR_W-1:0];
            end
            state_in = ST_DN_CMP;
         end

         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (left_big || right_big) begin
               wr_data = best_ent;
               hole_in = best_idx;
               if (next_left < cnt_ext) begin
                  rd_en    = 1'b1;
                  rd_addr  = next_left[ADDR_W-1:0];
                  state_in = ST_DN_LEFT;
               end else begin
                  state_in = ST_PLACE;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end

         // The moving entry settles in the hole.
         ST_PLACE: begin
            wr_en    = 1'b1;
            state_in = ST_FINISH;
         end

         // Hand the result to the output register once it is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in             = pend_ff;
               rsp_in.entry_count = COUNT_OUT_W'(count_ff);
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      mov_ff  <= mov_in;
      lft_ff  <= lft_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/mhpq_checker.sv
module mhpq_checker
   import mhpq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // At most one outcome flag per result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_payload.got_entry, rsp_payload.was_empty,
                                rsp_payload.was_full}) <= 1)
      else $error("more than one outcome flag on a result");

   // A remove that found nothing reports an empty heap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.was_empty) |-> (rsp_payload.entry_count == '0))
      else $error("empty remove with nonzero entry count");

   // A rejected insert reports a full heap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.was_full) |-> (rsp_payload.entry_count == OUT_FULL_COUNT))
      else $error("rejected insert without a full heap");

   // Without a returned entry the entry fields are zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.got_entry) |->
         (rsp_payload.out_id == '0 && rsp_payload.out_prio == '0))
      else $error("entry fields set on a result without an entry");

   // A stalled result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result changed or dropped while stalled");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);

### tb/sv/tb_max_heap_priority_queue.sv
module tb_max_heap_priority_queue;
   import mhpq_pkg::*;

   localparam int STIM_ITEMS   = 1200;
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // Items waiting to be sent, and the results the heap should return, oldest first.
   req_type req_backlog[$];
   rsp_type pending_results[$];

   // Shadow copy of the heap contents.
   entry_type heap_slots[HEAP_DEPTH];
   int        heap_fill = 0;

   // Fill level as seen while the item list is being built.
   int gen_fill = 0;

   int error_count    = 0;
   int accepted_count = 0;
   int insert_count   = 0;
   int remove_count   = 0;
   int returned_count = 0;
   int empty_count    = 0;
   int full_count     = 0;
   int quiet_cycles   = 0;

   max_heap_priority_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Both sides run without gaps for a stretch in the middle of the run.
   function automatic int idle_chance();
      if (accepted_count >= 450 && accepted_count < 650) begin
         return 0;
      end
      return 36;
   endfunction

   function automatic void swap_slots(int a, int b);
      entry_type t;
      t = heap_slots[a];
      heap_slots[a] = heap_slots[b];
      heap_slots[b] = t;
   endfunction

   // Applies one heap operation to the shadow copy and records the result it must give.
   function automatic void apply_heap_op(req_type item);
      rsp_type res;
      int      node;
      int      up;
      int      best;
      int      kid;
      bit      settled;
      res = '0;
      if (item.cmd == CMD_INSERT) begin
         insert_count++;
         if (heap_fill >= HEAP_DEPTH) begin
            res.was_full = 1'b1;
         end else begin
            heap_slots[heap_fill].proc_id = item.proc_id;
            heap_slots[heap_fill].prio = item.prio;
            node = heap_fill;
            heap_fill++;
            settled = 1'b0;
            // Move the new entry up past every strictly smaller parent.
            while (node > 0 && !settled) begin
               up = (node - 1) / 2;
               if (heap_slots[node].prio > heap_slots[up].prio) begin
                  swap_slots(node, up);
                  node = up;
               end else begin
                  settled = 1'b1;
               end
            end
         end
      end else begin
         remove_count++;
         if (heap_fill == 0) begin
            res.was_empty = 1'b1;
         end else begin
            res.out_id = heap_slots[0].proc_id;
            res.out_prio = heap_slots[0].prio;
            res.got_entry = 1'b1;
            heap_slots[0] = heap_slots[heap_fill - 1];
            heap_fill--;
            node = 0;
            settled = 1'b0;
            // Sink the moved entry; the left child wins a tie with the right one.
            while (node < heap_fill && !settled) begin
               best = node;
               kid = 2 * node + 1;
               if (kid < heap_fill && heap_slots[kid].prio > heap_slots[best].prio) begin
                  best = kid;
               end
               kid = 2 * node + 2;
               if (kid < heap_fill && heap_slots[kid].prio > heap_slots[best].prio) begin
                  best = kid;
               end
               if (best == node) begin
                  settled = 1'b1;
               end else begin
                  swap_slots(node, best);
                  node = best;
               end
            end
         end
      end
      res.entry_count = COUNT_OUT_W'(heap_fill);
      pending_results.push_back(res);
   endfunction

   task automatic queue_item(cmd_type cmd, int unsigned id, int unsigned pr);
      req_type item;
      item.cmd = cmd;
      item.proc_id = ID_W'(id);
      item.prio = PRIO_W'(pr);
      req_backlog.push_back(item);
      if (cmd == CMD_INSERT && gen_fill < HEAP_DEPTH) begin
         gen_fill++;
      end else if (cmd == CMD_REMOVE && gen_fill > 0) begin
         gen_fill--;
      end
   endtask

   // Priorities are either spread wide or drawn from a few values to force ties.
   function automatic int unsigned pick_prio(bit narrow);
      int unsigned few[4] = '{0, 1, 254, 255};
      if (narrow) begin
         return few[$urandom_range(0, 3)];
      end
      return $urandom_range(0, 255);
   endfunction

   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Driver: offers the next item from the backlog and predicts it on transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_heap_op(req_payload);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= idle_chance()) begin
               req_payload <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_payload);
               error_count++;
            end else begin
               exp_r = pending_results.pop_front();
               check_field("out_id", exp_r.out_id, rsp_payload.out_id);
               check_field("out_prio", exp_r.out_prio, rsp_payload.out_prio);
               check_field("got_entry", exp_r.got_entry, rsp_payload.got_entry);
               check_field("was_empty", exp_r.was_empty, rsp_payload.was_empty);
               check_field("was_full", exp_r.was_full, rsp_payload.was_full);
               check_field("entry_count", exp_r.entry_count, rsp_payload.entry_count);
               returned_count += exp_r.got_entry;
               empty_count += exp_r.was_empty;
               full_count += exp_r.was_full;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= idle_chance());
      end
   end

   // Count cycles in which neither channel moves a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int    stim_end;
      int    kind;
      int    seg;
      bit    narrow;
      int    i;
      // Directed part: empty remove, field extremes, ties, ignored remove fields.
      queue_item(CMD_REMOVE, 0, 0);
      queue_item(CMD_INSERT, 0, 0);
      queue_item(CMD_INSERT, 1023, 255);
      queue_item(CMD_INSERT, 'h155, 'hAA);
      queue_item(CMD_INSERT, 'h2AA, 'h55);
      queue_item(CMD_INSERT, 'h3FF, 'hAA);
      queue_item(CMD_INSERT, 'h001, 'hAA);
      queue_item(CMD_INSERT, 'h200, 'h01);
      queue_item(CMD_REMOVE, 1023, 255);
      for (i = 0; i < 7; i++) begin
         queue_item(CMD_REMOVE, 0, 0);
      end
      for (i = 1; i <= 4; i++) begin
         queue_item(CMD_INSERT, i, 'h80);
      end
      queue_item(CMD_REMOVE, 0, 0);
      queue_item(CMD_REMOVE, 'h2AA, 'h55);
      stim_end = req_backlog.size() + STIM_ITEMS;

      // Random part: fill to full and past it, drain to empty and past it, or mixed traffic.
      seg = 0;
      while (req_backlog.size() < stim_end) begin
         kind = (seg < 2) ? seg : $urandom_range(0, 2);
         narrow = ($urandom_range(0, 3) == 0);
         if (kind == 0) begin
            while (gen_fill < HEAP_DEPTH) begin
               queue_item(($urandom_range(0, 99) < 85) ? CMD_INSERT : CMD_REMOVE,
                          $urandom_range(0, 1023), pick_prio(narrow));
            end
            repeat ($urandom_range(1, 4)) queue_item(CMD_INSERT, $urandom_range(0, 1023),
                                                     pick_prio(narrow));
         end else if (kind == 1) begin
            while (gen_fill > 0) begin
               queue_item(($urandom_range(0, 99) < 85) ? CMD_REMOVE : CMD_INSERT,
                          $urandom_range(0, 1023), pick_prio(narrow));
            end
            repeat ($urandom_range(1, 3)) queue_item(CMD_REMOVE, $urandom_range(0, 1023),
                                                     pick_prio(narrow));
         end else begin
            repeat (40) queue_item(($urandom_range(0, 99) < 55) ? CMD_INSERT : CMD_REMOVE,
                                   $urandom_range(0, 1023), pick_prio(narrow));
         end
         seg++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to be sent and answered, then let the block settle.
      while (req_backlog.size() != 0 || req_valid || pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items: %0d inserts and %0d removes.",
               accepted_count, insert_count, remove_count);
      $display("Seen %0d entries returned, %0d removes on empty, %0d inserts turned away.",
               returned_count, empty_count, full_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
